// ----- rtl/core/msc_pkg.sv -----
package msc_pkg;

    // Configuration register indexes (byte address bits [4:2])
    localparam int unsigned AddrW = 5;
    localparam int unsigned IdxW  = 3;
    localparam logic [IdxW-1:0] REG_MAX_RPM  = 3'd0;
    localparam logic [IdxW-1:0] REG_PPR      = 3'd1;
    localparam logic [IdxW-1:0] REG_INVERT   = 3'd2;
    localparam logic [IdxW-1:0] REG_ADJ_PER  = 3'd3;
    localparam logic [IdxW-1:0] REG_STALL    = 3'd4;
    localparam logic [IdxW-1:0] REG_SAT_TIME = 3'd5;

    localparam logic [15:0] MAX_RPM_RST  = 16'd200;
    localparam logic [6:0]  PPR_RST      = 7'd1;
    localparam logic [15:0] ADJ_PER_RST  = 16'd250;
    localparam logic [15:0] STALL_RST    = 16'd500;
    localparam logic [15:0] SAT_TIME_RST = 16'd500;

    localparam logic [7:0]  FULL_DUTY = 8'd255;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // Shared divider
    localparam int unsigned DivW  = 24;
    localparam int unsigned StepW = 5;
    localparam logic [StepW-1:0] STEPS_RPM = StepW'(16);
    localparam logic [StepW-1:0] STEPS_OL  = StepW'(DivW);
    // 60000 aligned to the top of the dividend so only 16 steps are needed
    localparam logic [DivW-1:0] RpmNumAligned = DivW'(60000 << (DivW - 16));

    typedef struct packed {
        logic             start;
        logic [StepW-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [15:0] tick_up(input logic [15:0] t);
        tick_up = (t != TIMER_MAX) ? t + 16'd1 : TIMER_MAX;
    endfunction

endpackage

// ----- rtl/core/msc_div.sv -----
module msc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msc_pkg::div_ctl_t           ctl,
    input  logic [msc_pkg::DivW-1:0]    dividend,
    input  logic [msc_pkg::DivW-1:0]    divisor,
    output msc_pkg::div_stat_t          stat,
    output logic [msc_pkg::DivW-1:0]    quotient
);
    import msc_pkg::*;

    logic [DivW-1:0]  rem_reg;
    logic [DivW-1:0]  quo_reg;
    logic [DivW-1:0]  dsr_reg;
    logic [StepW-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DivW:0]    trial;
    logic             fits;

    // Restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DivW-1]} - {1'b0, dsr_reg};
    assign fits  = ~trial[DivW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - StepW'(1);
                if (cnt_reg == StepW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= trial[DivW-1:0];
            else
                rem_reg <= {rem_reg[DivW-2:0], quo_reg[DivW-1]};
            quo_reg <= {quo_reg[DivW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/core/motor_speed_step_controller.sv -----
// Channel   Direction  Handshake                     Payload
// tick      in         tick_valid / tick_ready       target_rpm[15:0] s, hall_level
// result    out        result_valid / result_ready   pwm_duty[7:0], dir_pin,
//                                                    drive_command[8:0] s,
//                                                    measured_rpm[15:0], saturated
// config    in         APB psel/penable/pwrite       paddr[4:0], pwdata/prdata[31:0]
//
// Each tick item runs the idle, command, adjust and output states when no division
// is needed (a zero target skips adjust); a hall active edge adds the speed division
// (16 divider steps) and a new target adds the open-loop division (24 divider steps),
// both in one item when both occur; the single shared restoring divider serves both.
// tick_ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next item is taken before the result is drained.
// A result stalled by result_ready low holds the sequencer before its output load.
// Reset (rst_n, asynchronous, active low) clears all control state and loads the
// register defaults; there is no clearing pass.
module motor_speed_step_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    // tick channel
    input  logic                      tick_valid,
    output logic                      tick_ready,
    input  logic signed [15:0]        target_rpm,
    input  logic                      hall_level,
    // result channel
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [7:0]                pwm_duty,
    output logic                      dir_pin,
    output logic signed [8:0]         drive_command,
    output logic [15:0]               measured_rpm,
    output logic                      saturated,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [msc_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import msc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_RPM_WAIT = 6'b000010,
        S_CMD      = 6'b000100,
        S_OL_WAIT  = 6'b001000,
        S_ADJ      = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    typedef struct packed {
        logic signed [8:0] cmd;
        logic              dir;
        logic              clr;
    } drive_t;

    // Clamp to +-255 and derive direction pin and full-duty timer clear
    function automatic drive_t apply_drive(input logic signed [9:0] v, input logic inv);
        drive_t d;
        if (v > 10'sd255)
            d.cmd = 9'sd255;
        else if (v < -10'sd255)
            d.cmd = -9'sd255;
        else
            d.cmd = v[8:0];
        d.dir = inv ? (d.cmd > 9'sd0) : (d.cmd <= 9'sd0);
        d.clr = (d.cmd != 9'sd255) && (d.cmd != -9'sd255);
        apply_drive = d;
    endfunction

    function automatic logic [7:0] mag_of(input logic signed [8:0] c);
        logic signed [8:0] n;
        n = -c;
        mag_of = c[8] ? n[7:0] : c[7:0];
    endfunction

    // Configuration registers
    logic [15:0] max_rpm_reg;
    logic [6:0]  ppr_reg;
    logic        invert_reg;
    logic [15:0] adj_period_reg;
    logic [15:0] stall_reg;
    logic [15:0] sat_time_reg;

    // Controller state
    state_t            state_reg;
    logic signed [8:0] cmd_reg;
    logic              dir_reg;
    logic signed [15:0] rem_target_reg;
    logic [15:0]       adj_reg;
    logic [15:0]       eit_reg;
    logic [15:0]       fdt_reg;
    logic              hall_prev_reg;
    logic [15:0]       rpm_reg;
    logic signed [15:0] tgt_reg;

    // Output register
    logic              result_valid_reg;
    logic [7:0]        duty_out_reg;
    logic              dir_out_reg;
    logic signed [8:0] cmd_out_reg;
    logic [15:0]       rpm_out_reg;
    logic              sat_out_reg;

    // Divider hookup
    div_ctl_t          div_ctl;
    div_stat_t         div_stat;
    logic [DivW-1:0]   div_dividend;
    logic [DivW-1:0]   div_divisor;
    logic [DivW-1:0]   div_quo;

    // Tick-front logic
    logic              accept;
    logic              active;
    logic              hall_edge;
    logic              hall_rise;
    logic [15:0]       adj_inc;
    logic [15:0]       eit_inc;
    logic [15:0]       fdt_inc;
    logic [7:0]        duty_now;
    logic [22:0]       prod;

    // Command path
    logic [15:0]       tgt_mag;
    logic [DivW-1:0]   ol_dividend;
    logic [7:0]        ol_mag;
    logic signed [9:0] ol_value;
    logic signed [17:0] cur_rpm;
    logic signed [17:0] tgt_wide;
    logic              adj_due;
    logic              step_down;
    logic              step_up;
    logic signed [9:0] drive_v;
    logic              drive_en;
    drive_t            drive;
    logic              out_free;
    logic              cfg_write;
    logic [IdxW-1:0]   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[AddrW-1:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_RPM:  prdata = {16'd0, max_rpm_reg};
            REG_PPR:      prdata = {25'd0, ppr_reg};
            REG_INVERT:   prdata = {31'd0, invert_reg};
            REG_ADJ_PER:  prdata = {16'd0, adj_period_reg};
            REG_STALL:    prdata = {16'd0, stall_reg};
            REG_SAT_TIME: prdata = {16'd0, sat_time_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign tick_ready = (state_reg == S_IDLE);
    assign accept     = tick_valid && tick_ready;

    // Timers advance first, then the hall is sampled
    assign active    = ~hall_level;
    assign hall_edge = (active != hall_prev_reg);
    assign hall_rise = hall_edge && active;
    assign adj_inc   = tick_up(adj_reg);
    assign eit_inc   = tick_up(eit_reg);
    assign duty_now  = mag_of(cmd_reg);
    assign fdt_inc   = (duty_now == FULL_DUTY) ? tick_up(fdt_reg) : fdt_reg;
    assign prod      = {7'd0, eit_inc} * {16'd0, ppr_reg};

    // Open-loop command: |target| * 255 / max_rpm, sign restored afterwards
    assign tgt_mag     = tgt_reg[15] ? 16'(-tgt_reg) : tgt_reg;
    assign ol_dividend = ({8'd0, tgt_mag} << 8) - {8'd0, tgt_mag};
    assign ol_mag      = (div_quo > DivW'(FULL_DUTY)) ? FULL_DUTY : div_quo[7:0];
    assign ol_value    = tgt_reg[15] ? -$signed({2'b00, ol_mag}) : $signed({2'b00, ol_mag});

    // Closed-loop step: compare target with the speed signed by direction
    assign cur_rpm   = (invert_reg ^ dir_reg) ? -$signed({2'b00, rpm_reg})
                                              : $signed({2'b00, rpm_reg});
    assign tgt_wide  = 18'(tgt_reg);
    assign adj_due   = (adj_reg > adj_period_reg);
    assign step_down = (tgt_wide < cur_rpm);
    assign step_up   = (tgt_wide > cur_rpm);

    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.steps = STEPS_RPM;
        div_dividend  = RpmNumAligned;
        div_divisor   = {1'b0, prod};
        drive_v       = '0;
        drive_en      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                div_ctl.start = accept && hall_rise && (prod != 23'd0);
            end
            S_CMD:
            begin
                div_ctl.start = (tgt_reg != 16'sd0) && (tgt_reg != rem_target_reg);
                div_ctl.steps = STEPS_OL;
                div_dividend  = ol_dividend;
                div_divisor   = (max_rpm_reg == 16'd0) ? DivW'(1) : DivW'(max_rpm_reg);
                drive_en      = (tgt_reg == 16'sd0);
            end
            S_OL_WAIT:
            begin
                drive_v  = ol_value;
                drive_en = div_stat.done;
            end
            S_ADJ:
            begin
                drive_v  = step_down ? 10'(cmd_reg) - 10'sd1 : 10'(cmd_reg) + 10'sd1;
                drive_en = adj_due && (step_down || step_up);
            end
            default:
            begin
            end
        endcase
    end

    assign drive    = apply_drive(drive_v, invert_reg);
    assign out_free = !result_valid_reg || result_ready;

    msc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rpm_reg    <= MAX_RPM_RST;
            ppr_reg        <= PPR_RST;
            invert_reg     <= 1'b0;
            adj_period_reg <= ADJ_PER_RST;
            stall_reg      <= STALL_RST;
            sat_time_reg   <= SAT_TIME_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_MAX_RPM:  max_rpm_reg    <= pwdata[15:0];
                REG_PPR:      ppr_reg        <= pwdata[6:0];
                REG_INVERT:   invert_reg     <= pwdata[0];
                REG_ADJ_PER:  adj_period_reg <= pwdata[15:0];
                REG_STALL:    stall_reg      <= pwdata[15:0];
                REG_SAT_TIME: sat_time_reg   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= '0;
            dir_reg          <= 1'b0;
            rem_target_reg   <= '0;
            adj_reg          <= '0;
            eit_reg          <= '0;
            fdt_reg          <= '0;
            hall_prev_reg    <= 1'b0;
            rpm_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on the output load, drop it once the item is taken
            if ((state_reg == S_OUT) && out_free)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (drive_en)
            begin
                cmd_reg <= drive.cmd;
                dir_reg <= drive.dir;
                if (drive.clr)
                    fdt_reg <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        adj_reg <= adj_inc;
                        eit_reg <= hall_rise ? 16'd0 : eit_inc;
                        fdt_reg <= fdt_inc;
                        if (hall_edge)
                            hall_prev_reg <= active;
                        // zero product gives zero speed; stall check only without edge
                        if (hall_rise && (prod == 23'd0))
                            rpm_reg <= '0;
                        else if (!hall_edge && (eit_inc >= stall_reg))
                            rpm_reg <= '0;
                        state_reg <= div_ctl.start ? S_RPM_WAIT : S_CMD;
                    end
                end
                S_RPM_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        rpm_reg   <= div_quo[15:0];
                        state_reg <= S_CMD;
                    end
                end
                S_CMD:
                begin
                    if (tgt_reg == 16'sd0)
                        state_reg <= S_OUT;
                    else if (div_ctl.start)
                    begin
                        rem_target_reg <= tgt_reg;
                        adj_reg        <= '0;
                        state_reg      <= S_OL_WAIT;
                    end
                    else
                        state_reg <= S_ADJ;
                end
                S_OL_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= S_ADJ;
                end
                S_ADJ:
                begin
                    if (adj_due)
                        adj_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Latch the tick payload and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            tgt_reg <= target_rpm;
        if ((state_reg == S_OUT) && out_free)
        begin
            duty_out_reg <= duty_now;
            dir_out_reg  <= dir_reg;
            cmd_out_reg  <= cmd_reg;
            rpm_out_reg  <= rpm_reg;
            sat_out_reg  <= (duty_now == FULL_DUTY) && (fdt_reg >= sat_time_reg);
        end
    end

    assign result_valid  = result_valid_reg;
    assign pwm_duty      = duty_out_reg;
    assign dir_pin       = dir_out_reg;
    assign drive_command = cmd_out_reg;
    assign measured_rpm  = rpm_out_reg;
    assign saturated     = sat_out_reg;

    // Waiting on the divider while it is idle would hang the sequencer
    a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RPM_WAIT) || (state_reg == S_OL_WAIT)) |->
            (div_stat.busy || div_stat.done))
        else $error("sequencer waits on an idle divider");

    // The divider is never restarted in the middle of a division
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // The command stays inside +-255
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg != -9'sd256)
        else $error("command out of range");

    // The measured speed never exceeds the numerator of the speed formula
    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpm_reg <= 16'd60000)
        else $error("measured speed out of range");

    // A result is loaded only at the end of a tick
    a_load_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import msc_pkg::*;

    // Drive command limit in plain integer terms for the speed predictor
    localparam int CMD_LIMIT = FULL_DUTY;

    // Register slots past the last defined one; writes there must change nothing
    localparam logic [IdxW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IdxW-1:0] REG_SPARE_B = 3'd7;

    // Idle cycles to let pass once the last result is in, and the drain bound
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 200;

    typedef enum logic [0:0] {
        RDY_ALWAYS,
        RDY_PATTERN
    } ready_mode_t;

    // One expected drive result, laid out like the result channel
    typedef struct packed {
        logic [7:0]  duty;
        logic        dir;
        logic [8:0]  cmd;
        logic [15:0] rpm;
        logic        sat;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               tick_valid;
    logic               tick_ready;
    logic signed [15:0] target_rpm;
    logic               hall_level;

    logic               result_valid;
    logic               result_ready;
    logic [7:0]         pwm_duty;
    logic               dir_pin;
    logic signed [8:0]  drive_command;
    logic [15:0]        measured_rpm;
    logic               saturated;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    motor_speed_step_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_ready    (tick_ready),
        .target_rpm    (target_rpm),
        .hall_level    (hall_level),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pwm_duty      (pwm_duty),
        .dir_pin       (dir_pin),
        .drive_command (drive_command),
        .measured_rpm  (measured_rpm),
        .saturated     (saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Speed controller predictor: shadow configuration and control state
    // ------------------------------------------------------------------
    int unsigned cfg_max_rpm;
    int unsigned cfg_ppr;
    bit          cfg_invert;
    int unsigned cfg_adjust;
    int unsigned cfg_stall;
    int unsigned cfg_sat_time;

    int          drv_cmd;
    bit          dir_state;
    int          target_mem;
    int unsigned adj_timer;
    int unsigned edge_timer;
    int unsigned full_timer;
    bit          hall_was_active;
    int unsigned rpm_state;

    // Expected drive results, oldest first
    drive_result_t expected_drive_q[$];

    int          mismatches;
    int          results_seen;

    // Sender and receiver pacing knobs, set by the tests
    int          gap_max;
    int          burst_left;
    ready_mode_t ready_mode;
    int          hold_request;
    int          hold_left;
    int          ready_run_left;
    bit          ready_level;

    function automatic int unsigned timer_step(int unsigned t);
        return (t < TIMER_MAX) ? t + 1 : TIMER_MAX;
    endfunction

    function automatic int magnitude(int c);
        return (c < 0) ? -c : c;
    endfunction

    // Load a new command: clamp, refresh the direction pin, and drop the
    // full-duty timer whenever duty falls below full scale
    function automatic void drive_to(int v);
        drv_cmd = (v > CMD_LIMIT) ? CMD_LIMIT : ((v < -CMD_LIMIT) ? -CMD_LIMIT : v);
        dir_state = cfg_invert ? (drv_cmd > 0) : (drv_cmd <= 0);
        if (magnitude(drv_cmd) < CMD_LIMIT)
            full_timer = 0;
    endfunction

    // One millisecond tick: timers, then hall sampling, then control, then outputs
    function automatic drive_result_t predict_tick(logic signed [15:0] tgt, logic hall);
        int            t;
        bit            active;
        int unsigned   prod;
        int            divisor;
        int            cur;
        drive_result_t r;
        t = tgt;
        active = !hall;

        adj_timer = timer_step(adj_timer);
        edge_timer = timer_step(edge_timer);
        if (magnitude(drv_cmd) >= CMD_LIMIT)
            full_timer = timer_step(full_timer);

        if (active != hall_was_active)
        begin
            // an edge toward inactive only records the level; no stall check
            hall_was_active = active;
            if (active)
            begin
                prod = edge_timer * cfg_ppr;
                rpm_state = (prod == 0) ? 0 : 60000 / prod;
                edge_timer = 0;
            end
        end
        else if (edge_timer >= cfg_stall)
            rpm_state = 0;

        if (t == 0)
            drive_to(0);
        else
        begin
            if (t != target_mem)
            begin
                divisor = (cfg_max_rpm == 0) ? 1 : cfg_max_rpm;
                target_mem = t;
                adj_timer = 0;
                drive_to((t * CMD_LIMIT) / divisor);
            end
            if (adj_timer > cfg_adjust)
            begin
                cur = rpm_state;
                adj_timer = 0;
                if ((cfg_invert ^ dir_state) != 0)
                    cur = -cur;
                if (t < cur)
                    drive_to(drv_cmd - 1);
                else if (t > cur)
                    drive_to(drv_cmd + 1);
            end
        end

        r.duty = 8'(magnitude(drv_cmd));
        r.dir  = dir_state;
        r.cmd  = 9'(drv_cmd);
        r.rpm  = 16'(rpm_state);
        r.sat  = (magnitude(drv_cmd) >= CMD_LIMIT) && (full_timer >= cfg_sat_time);
        return r;
    endfunction

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR @%0t result %0d: %s got %0d want %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest
    // expectation, field by field. Sample at the edge, before the NBA
    // region, so values seen are the ones the handshake moved.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_drive_q.size() == 0)
                report_mismatch("result with nothing expected", int'(drive_command), 0);
            else
            begin
                want = expected_drive_q.pop_front();
                if (pwm_duty !== want.duty)
                    report_mismatch("pwm_duty", pwm_duty, want.duty);
                if (dir_pin !== want.dir)
                    report_mismatch("dir_pin", dir_pin, want.dir);
                if (drive_command !== want.cmd)
                    report_mismatch("drive_command", drive_command, $signed(want.cmd));
                if (measured_rpm !== want.rpm)
                    report_mismatch("measured_rpm", measured_rpm, want.rpm);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a long hold-off when a test asks for one, otherwise either
    // always ready or random runs of ready/stall (mostly ready)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (ready_mode == RDY_ALWAYS)
            result_ready <= 1'b1;
        else
        begin
            if (ready_run_left == 0)
            begin
                ready_level = ($urandom_range(0, 3) != 0);
                ready_run_left = $urandom_range(1, 12);
            end
            ready_run_left--;
            result_ready <= ready_level;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // One APB transfer: setup cycle, access cycle, then idle with psel low so
    // back-to-back transfers never drive psel twice in one step
    task automatic apb_access(input logic [IdxW-1:0] idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, mirror it in the predictor, and read it back
    task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] value);
        logic [31:0] kept;
        logic [31:0] rd;
        bit          known;
        known = 1'b1;
        case (idx)
            REG_MAX_RPM:  begin kept = value & 32'hFFFF; cfg_max_rpm  = kept; end
            REG_PPR:      begin kept = value & 32'h7F;   cfg_ppr      = kept; end
            REG_INVERT:   begin kept = value & 32'h1;    cfg_invert   = kept[0]; end
            REG_ADJ_PER:  begin kept = value & 32'hFFFF; cfg_adjust   = kept; end
            REG_STALL:    begin kept = value & 32'hFFFF; cfg_stall    = kept; end
            REG_SAT_TIME: begin kept = value & 32'hFFFF; cfg_sat_time = kept; end
            default:      begin kept = '0; known = 1'b0; end
        endcase
        apb_access(idx, 1'b1, value, rd);
        if (known)
        begin
            apb_access(idx, 1'b0, '0, rd);
            if (rd !== kept)
                report_mismatch("register read back", rd, kept);
        end
    endtask

    task automatic apply_settings(int unsigned mx, int unsigned ppr, int unsigned inv,
                                  int unsigned adj, int unsigned stall, int unsigned sat);
        write_reg(REG_MAX_RPM, mx);
        write_reg(REG_PPR, ppr);
        write_reg(REG_INVERT, inv);
        write_reg(REG_ADJ_PER, adj);
        write_reg(REG_STALL, stall);
        write_reg(REG_SAT_TIME, sat);
    endtask

    // ------------------------------------------------------------------
    // Tick sender
    // ------------------------------------------------------------------

    // Offer one tick item and hold it until taken; predict at acceptance.
    // Between bursts drop valid for a random gap; inside a burst keep it high.
    task automatic send_tick(logic signed [15:0] tgt, logic hall);
        int gap;
        tick_valid <= 1'b1;
        target_rpm <= tgt;
        hall_level <= hall;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        expected_drive_q.push_back(predict_tick(tgt, hall));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                tick_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    // Drop valid after the last item of a sequence
    task automatic sender_idle();
        tick_valid <= 1'b0;
    endtask

    // Hold off until every expected result is in, then let the block settle
    task automatic wait_drained();
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Mostly speeds the hall pattern can reach; sometimes stop or extremes
    function automatic logic signed [15:0] pick_target(int span);
        int mag;
        case ($urandom_range(0, 7))
            0: return 16'sd0;
            1: return ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32767;
            2: return ($urandom_range(0, 1) != 0) ? -16'sd32768 : 16'sd1;
            default: mag = $urandom_range(1, span);
        endcase
        return ($urandom_range(0, 1) != 0) ? 16'(mag) : 16'(-mag);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset, then open-loop extremes, hall edges, stall
    // timeout, the inactive-edge case, saturation flag and zero target
    task automatic test_open_loop_directed();
        send_tick(16'sd0, 1'b1);
        send_tick(16'sd100, 1'b0);
        sender_idle();
        wait_drained();
        apply_settings(200, 1, 0, 1, 3, 2);
        send_tick(16'sd0, 1'b1);
        send_tick(16'sd32767, 1'b1);
        send_tick(16'sd32767, 1'b0);
        send_tick(16'sd32767, 1'b0);
        // inactive edge right at the stall count: reading must survive it
        send_tick(16'sd32767, 1'b1);
        send_tick(16'sd32767, 1'b1);
        send_tick(-16'sd32768, 1'b1);
        send_tick(-16'sd32768, 1'b0);
        send_tick(-16'sd32767, 1'b1);
        send_tick(16'sd1, 1'b0);
        send_tick(16'sd1, 1'b1);
        send_tick(16'sd1, 1'b1);
        // zero target stops the drive but keeps the remembered target
        send_tick(16'sd0, 1'b1);
        send_tick(16'sd1, 1'b0);
        send_tick(-16'sd1, 1'b1);
        send_tick(-16'sd1, 1'b1);
        send_tick(-16'sd1, 1'b1);
        sender_idle();
    endtask

    // No pulses per rev gives zero speed; zero max rpm acts as one
    task automatic test_degenerate_config();
        wait_drained();
        write_reg(REG_PPR, 0);
        write_reg(REG_MAX_RPM, 0);
        send_tick(16'sd5, 1'b1);
        send_tick(16'sd5, 1'b0);
        send_tick(16'sd5, 1'b1);
        send_tick(-16'sd5, 1'b0);
        sender_idle();
    endtask

    // Writes to undefined register slots must leave the settings alone
    task automatic test_unknown_register();
        wait_drained();
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0000_0000);
        send_tick(16'sd7, 1'b1);
        send_tick(16'sd7, 1'b0);
        sender_idle();
    endtask

    // Long receiver hold-off with the sender pushing back to back, so the
    // block fills and stalls its input; then pause until all results are in
    task automatic test_backpressure();
        int k;
        wait_drained();
        apply_settings(3000, 2, 1, 2, 50, 4);
        gap_max = 0;
        ready_mode = RDY_PATTERN;
        hold_request = 400;
        for (k = 0; k < 30; k++)
            send_tick(pick_target(15000), ((k % 6) < 2) ? 1'b0 : 1'b1);
        sender_idle();
        wait_drained();
        for (k = 0; k < 6; k++)
            send_tick(16'sd2000, ((k % 3) == 0) ? 1'b0 : 1'b1);
        sender_idle();
    endtask

    // Random segments: mostly a steady target with a periodic hall pattern,
    // plus noise, frequent target changes and a hall stuck inactive
    task automatic test_speed_loop_random(int unsigned mx, int unsigned ppr, int unsigned inv,
                                          int unsigned adj, int unsigned stall,
                                          int unsigned sat, int n_items, int span);
        int                 sent;
        int                 seg_kind;
        int                 seg_len;
        int                 hall_period;
        int                 active_len;
        int                 ph;
        int                 k;
        logic signed [15:0] tgt;
        logic               hall;
        wait_drained();
        apply_settings(mx, ppr, inv, adj, stall, sat);
        sent = 0;
        while (sent < n_items)
        begin
            seg_kind    = $urandom_range(0, 9);
            seg_len     = $urandom_range(8, 60);
            hall_period = $urandom_range(2, 40);
            active_len  = $urandom_range(1, hall_period - 1);
            ph          = $urandom_range(0, hall_period - 1);
            tgt         = pick_target(span);
            for (k = 0; k < seg_len && sent < n_items; k++)
            begin
                hall = (((ph + k) % hall_period) < active_len) ? 1'b0 : 1'b1;
                case (seg_kind)
                    0:
                    begin
                        tgt  = 16'($urandom);
                        hall = 1'($urandom);
                    end
                    1:
                        if ($urandom_range(0, 3) == 0)
                            tgt = pick_target(span);
                    2:
                        hall = 1'b1;
                    default: ;
                endcase
                send_tick(tgt, hall);
                sent++;
            end
        end
        sender_idle();
    endtask

    // ------------------------------------------------------------------
    // Watchdog: fail the run if it never reaches its end
    // ------------------------------------------------------------------
    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int drain_wait;

        // Park every input at a known value before the first edge
        rst_n        <= 1'b0;
        tick_valid   <= 1'b0;
        target_rpm   <= '0;
        hall_level   <= 1'b1;
        result_ready <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        // Predictor starts from the reset defaults
        cfg_max_rpm     = MAX_RPM_RST;
        cfg_ppr         = PPR_RST;
        cfg_invert      = 1'b0;
        cfg_adjust      = ADJ_PER_RST;
        cfg_stall       = STALL_RST;
        cfg_sat_time    = SAT_TIME_RST;
        drv_cmd         = 0;
        dir_state       = 1'b0;
        target_mem      = 0;
        adj_timer       = 0;
        edge_timer      = 0;
        full_timer      = 0;
        hall_was_active = 1'b0;
        rpm_state       = 0;

        mismatches     = 0;
        results_seen   = 0;
        gap_max        = 4;
        burst_left     = 0;
        ready_mode     = RDY_PATTERN;
        hold_request   = 0;
        hold_left      = 0;
        ready_run_left = 0;
        ready_level    = 1'b1;

        // Hold reset low, then release it on an edge
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_open_loop_directed();
        test_degenerate_config();
        test_unknown_register();
        test_backpressure();

        // Closed loop at several settings, extremes among them
        gap_max = 6;
        ready_mode = RDY_PATTERN;
        test_speed_loop_random(200, 1, 0, 2, 40, 5, 220, 30000);
        // no idling on either side for this stretch
        gap_max = 0;
        ready_mode = RDY_ALWAYS;
        test_speed_loop_random(65535, 64, 1, 1, 1, 1, 220, 500);
        gap_max = 8;
        ready_mode = RDY_PATTERN;
        test_speed_loop_random(1, 3, 0, 65535, 65535, 65535, 220, 10000);
        test_speed_loop_random($urandom_range(1, 65535), $urandom_range(1, 64),
                               $urandom_range(0, 1), $urandom_range(1, 8),
                               $urandom_range(1, 120), $urandom_range(1, 30), 220, 20000);
        gap_max = 3;
        test_speed_loop_random(5000, 2, 1, 3, 100, 20, 220, 15000);

        // Wait for the last results, bounded, then let the block settle
        drain_wait = 0;
        while (expected_drive_q.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (expected_drive_q.size() != 0)
            report_mismatch("results never arrived", expected_drive_q.size(), 0);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
